// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the queue RTL.
// Every check is clocked on clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk once reset has been released.
`define CHK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an implication holds on the next rising edge.
`define CHK_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ----- rtl/core/fsfq_pkg.sv -----
package fsfq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CAP_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b1;

	localparam logic POL_FIFO     = 1'b0;
	localparam logic POL_SMALLEST = 1'b1;

	typedef enum logic {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] request_tag;
		logic [31:0] file_size;
		logic        req_static;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] out_tag;
		logic [31:0] out_size;
		logic        out_static;
	} out_item_t;

	// One stored entry.
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] size;
		logic        stat;
	} entry_t;

	// Controller sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} fsm_t;

endpackage

// ----- rtl/core/fsfq_mem.sv -----
module fsfq_mem
	import fsfq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	// Simple dual-port storage, one write and one registered read per cycle.
	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/fsfq_ctrl.sv -----
`include "assert_macros.svh"

module fsfq_ctrl
	import fsfq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	input  logic             policy,
	input  logic [CAP_W-1:0] capacity,
	output logic             res_valid,
	input  logic             res_ready,
	output out_item_t        res,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output entry_t           wr_data,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  entry_t           rd_data
);

	localparam int XW = (CW > CAP_W) ? CW : CAP_W;

	fsm_t          state_q, state_n;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] last_q;
	logic [CW-1:0] best_idx_q;
	entry_t        best_q;
	out_item_t     res_q;
	logic          rd_valid_s1;
	logic [CW-1:0] rd_idx_s1;

	logic          accept;
	logic          full;
	logic [CW-1:0] rd_ptr;
	logic [CW-1:0] wr_idx;
	logic          take;
	logic [CW-1:0] best_idx_n;
	entry_t        pick;
	logic          scan_end;
	logic          shift_end;
	status_t       acc_status;

	assign accept = in_valid && !in_stall;
	assign full   = (XW'(count_q) >= XW'(capacity)) || (XW'(count_q) >= XW'(DEPTH));

	// Later entries win ties, so an equal size replaces the current best.
	assign take       = (rd_idx_s1 == '0) || (rd_data.size <= best_q.size);
	assign best_idx_n = take ? rd_idx_s1 : best_idx_q;
	assign pick       = take ? rd_data : best_q;
	assign scan_end   = (state_q == S_SCAN) && rd_valid_s1 && (rd_idx_s1 == last_q);
	assign shift_end  = (state_q == S_SHIFT) && !rd_en && !rd_valid_s1;
	assign wr_idx     = rd_idx_s1 - CW'(1);

	// Status of the item being accepted; a dequeue that finds entries is
	// completed later by the scan.
	always_comb begin
		acc_status = STAT_DONE;
		if (in_item.action == ACT_ENQ && full) begin
			acc_status = STAT_FULL;
		end
		if (in_item.action == ACT_DEQ && count_q == '0) begin
			acc_status = STAT_EMPTY;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_item.action == ACT_DEQ && count_q != '0) begin
						state_n = S_SCAN;
					end else begin
						state_n = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_n = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (shift_end) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = count_q[AW-1:0];
		wr_data   = '{tag: in_item.request_tag, size: in_item.file_size,
		              stat: in_item.req_static};
		rd_en     = 1'b0;
		rd_ptr    = ptr_q;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				rd_ptr   = '0;
				if (in_valid && in_item.action == ACT_ENQ && !full) begin
					wr_en = 1'b1;
				end
				if (in_valid && in_item.action == ACT_DEQ && count_q != '0) begin
					rd_en = 1'b1;
				end
			end
			S_SCAN: begin
				rd_en = (ptr_q <= last_q);
			end
			S_SHIFT: begin
				rd_en   = (ptr_q < count_q);
				wr_en   = rd_valid_s1;
				wr_addr = wr_idx[AW-1:0];
				wr_data = rd_data;
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	assign rd_addr = rd_ptr[AW-1:0];
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			last_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_n;
			rd_valid_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_item.action == ACT_ENQ && !full) begin
							count_q <= count_q + CW'(1);
						end
						ptr_q  <= CW'(1);
						last_q <= (policy == POL_SMALLEST) ? count_q - CW'(1) : '0;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						ptr_q <= best_idx_n + CW'(1);
					end else if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				S_SHIFT: begin
					if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (shift_end) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr;
		if (state_q == S_SCAN && rd_valid_s1) begin
			best_q     <= pick;
			best_idx_q <= best_idx_n;
		end
		if (accept) begin
			res_q <= '{status: acc_status, out_tag: '0, out_size: '0, out_static: 1'b0};
		end else if (scan_end) begin
			res_q <= '{status: STAT_DONE, out_tag: pick.tag, out_size: pick.size,
			           out_static: pick.stat};
		end
	end

	`CHK_CLK(a_count_in_range, XW'(count_q) <= XW'(DEPTH), "entry count above depth")
	`CHK_CLK(a_shift_write_below_count,
		!(wr_en && state_q == S_SHIFT) || (wr_idx < count_q),
		"gap closing writes past the held entries")
	`CHK_NEXT(a_full_keeps_count,
		accept && in_item.action == ACT_ENQ && full, $stable(count_q),
		"rejected enqueue changed the count")
	`CHK_NEXT(a_scan_goes_shift, scan_end, state_q == S_SHIFT,
		"scan end did not start the gap close")

endmodule

// ----- rtl/core/fifo_or_smallest_first_queue.sv -----
// Bounded request queue with a selectable service order. Each input item is
// either an enqueue (tag, size, static flag) or a dequeue, and every item
// produces exactly one result item. An enqueue stores its entry when fewer
// than the programmed capacity (saturated at DEPTH) are held and answers
// "done"; otherwise it answers "full" and the entry is dropped. A dequeue
// answers "empty" when nothing is held; otherwise it returns one entry: the
// oldest one in FIFO policy, or in smallest-first policy the entry with the
// least size, the most recently enqueued one among equal sizes. Entries are
// kept in arrival order in a single memory, and removing one moves every
// later entry down one slot. A smallest-first dequeue scans all held
// entries for the smallest size, and the gap close then walks the entries
// behind the one taken, both through the memory's one read port, one entry
// per cycle. Input items are taken only while the sequencer is idle, but a
// finished result may still wait in the output register while the next
// item is accepted. Configuration writes are always ready and must only be
// issued while the queue is idle.

`include "assert_macros.svh"

module fifo_or_smallest_first_queue
	import fsfq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// Configuration registers.
	logic             policy_q;
	logic [CAP_W-1:0] capacity_q;

	// Output register that decouples the result from the sequencer.
	logic      out_valid_q;
	out_item_t out_q;

	logic          res_valid;
	logic          res_ready;
	out_item_t     res;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= POL_FIFO;
			capacity_q <= CAP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POLICY:   policy_q   <= cfg_data[0];
				CFG_CAPACITY: capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The sequencer may hand over a result whenever the output register is
	// empty or is being emptied in this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	fsfq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.policy    (policy_q),
		.capacity  (capacity_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	fsfq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// A result handed over always lands in the output register.
	`CHK_NEXT(a_result_lands, res_valid && res_ready, out_valid_q,
		"result lost on its way to the output register")
	// A held result is never overwritten while the consumer stalls.
	`CHK_NEXT(a_held_result_kept, out_valid_q && out_stall, $stable(out_q) && out_valid_q,
		"output register changed under stall")

endmodule

// ----- dv/fifo_or_smallest_first_queue_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the request queue. A scoreboard object keeps its own copy
// of the held entries and of the two registers. It works out the result of every
// accepted request item and checks the result items in order. Plain tasks drive
// the request and register channels; a receiver process stalls the result channel.
module fifo_or_smallest_first_queue_test;
	import fsfq_pkg::*;

	// The slowest correct item is a smallest-first dequeue on a full queue.
	// The limit leaves plenty of room above that for roughly 1700 items.
	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 205;

	// Holds the entries the queue should contain and the results still to come.
	class queue_scoreboard;
		entry_t           held[$];
		out_item_t        expected_results[$];
		logic             policy;
		logic [CAP_W-1:0] capacity;
		int               errors;

		function new();
			policy   = POL_FIFO;
			capacity = CAP_W'(1);
			errors   = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
			if (idx == CFG_POLICY) begin
				policy = data[0];
			end else begin
				capacity = data;
			end
		endfunction

		// Records one accepted request item and works out its result.
		function void note_request(in_item_t it);
			out_item_t r;
			entry_t    e;
			int        limit;
			int        k;
			r = '0;
			r.status = STAT_DONE;
			limit = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
			if (it.action == ACT_ENQ) begin
				if (held.size() >= limit) begin
					r.status = STAT_FULL;
				end else begin
					e.tag  = it.request_tag;
					e.size = it.file_size;
					e.stat = it.req_static;
					held.push_back(e);
				end
			end else if (held.size() == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				// Smallest size wins, and the later arrival wins a tie.
				k = 0;
				if (policy == POL_SMALLEST) begin
					for (int i = 1; i < held.size(); i++) begin
						if (held[i].size <= held[k].size) k = i;
					end
				end
				r.out_tag    = held[k].tag;
				r.out_size   = held[k].size;
				r.out_static = held[k].stat;
				held.delete(k);
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				$error("result item arrived with no expectation pending");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.out_tag !== want.out_tag) begin
				$error("out_tag: expected %h, actual %h", want.out_tag, got.out_tag);
				errors++;
			end
			if (got.out_size !== want.out_size) begin
				$error("out_size: expected %h, actual %h", want.out_size, got.out_size);
				errors++;
			end
			if (got.out_static !== want.out_static) begin
				$error("out_static: expected %b, actual %b", want.out_static, got.out_static);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAP_W-1:0]     cfg_data;

	queue_scoreboard sb;
	// The two flags below pass requests between the sender and the receiver.
	bit              quiet;
	bit              long_hold;
	int              cycles;

	fifo_or_smallest_first_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle counter. A hang ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result monitor. It samples at the rising edge, before the block's own
	// updates for that edge take effect.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_item);
	end

	// Receiver. It stalls in random bursts, and it stays quiet in the last
	// phase. When the sender asks for a long hold, the receiver keeps stall
	// high on its own and then clears the request. The sender keeps offering
	// items meanwhile, so results back up into the sequencer and the block
	// stalls its input.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one item and returns at the falling edge after it was accepted.
	// Valid is left high. The caller either offers the next item or lowers
	// valid in that same time step.
	task automatic send_item(in_item_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		sb.note_request(it);
		@(negedge clk);
	endtask

	task automatic enq(logic [15:0] tag, logic [31:0] size, logic stat);
		in_item_t it;
		it.action      = ACT_ENQ;
		it.request_tag = tag;
		it.file_size   = size;
		it.req_static  = stat;
		send_item(it);
	endtask

	// The request fields carry random values on a dequeue, since the block
	// must ignore them.
	task automatic deq();
		in_item_t it;
		it.action      = ACT_DEQ;
		it.request_tag = 16'($urandom);
		it.file_size   = $urandom;
		it.req_static  = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	task automatic pause(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Waits until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
	endtask

	// Writes both registers once the queue is idle. Held entries stay in
	// place. The upper bits of the policy data are random, and only bit 0
	// counts.
	task automatic set_config(logic pol, logic [CAP_W-1:0] cap);
		drain();
		repeat (4) @(negedge clk);
		cfg_write(CFG_POLICY, {4'($urandom_range(0, 15)), pol});
		cfg_write(CFG_CAPACITY, cap);
		cfg_valid <= 1'b0;
	endtask

	// Random item. Enqueues come with a given chance. Sizes are often small,
	// so that ties come up, and sometimes sit at the corners of the range.
	function automatic in_item_t random_request(int enq_pct);
		in_item_t it;
		it.action      = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
		it.request_tag = 16'($urandom);
		it.req_static  = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: it.file_size = $urandom_range(0, 7);
			1: it.file_size = $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: it.file_size = 32'h0000_0000;
					1: it.file_size = 32'hFFFF_FFFF;
					2: it.file_size = 32'h8000_0000;
					default: it.file_size = 32'h7FFF_FFFF;
				endcase
			end
			default: it.file_size = $urandom_range(0, 1000);
		endcase
		return it;
	endfunction

	initial begin
		logic [CAP_W-1:0] caps [PHASES];
		logic             pols [PHASES];
		int               n;
		int               burst;
		int               pct;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_POLICY;
		cfg_data  = '0;
		quiet     = 1'b0;
		long_hold = 1'b0;
		cycles    = 0;
		sb        = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: FIFO order with room for one entry. This covers a
		// dequeue on an empty queue, an enqueue with every field at its top
		// value, and an enqueue rejected as full.
		deq();
		enq(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		enq(16'h0000, 32'h0000_0000, 1'b0);
		deq();

		// Smallest-first order: two pairs of equal sizes, and the two dequeues take
		// the zero-size pair, later arrival first. The extremes of size are in the mix.
		set_config(POL_SMALLEST, 5'd16);
		enq(16'd1, 32'd5, 1'b0);
		enq(16'd0, 32'd0, 1'b1);
		enq(16'd2, 32'd5, 1'b1);
		enq(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		enq(16'd3, 32'd0, 1'b0);
		deq();
		deq();

		// Policy changes and capacity drops below the count while three
		// entries are held. Enqueues are rejected until the count falls.
		set_config(POL_FIFO, 5'd2);
		enq(16'd4, 32'd7, 1'b0);
		deq();
		deq();
		enq(16'd5, 32'd9, 1'b1);

		// Capacity zero: every enqueue is full, and dequeues still drain.
		set_config(POL_SMALLEST, 5'd0);
		enq(16'd6, 32'd1, 1'b0);
		deq();
		deq();
		deq();

		// Random phases. The settings include the extremes: capacity 0, 1,
		// full depth, and values above the depth, which saturate. Entries
		// carry over from one phase to the next. Bursts lean toward either
		// filling or draining, so the queue keeps running between empty
		// and full.
		caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd16, 5'd5,
			5'($urandom_range(17, 31)), 5'($urandom_range(1, 16))};
		pols = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		for (int p = 0; p < PHASES; p++) begin
			set_config(pols[p], caps[p]);
			// The last phase runs without idling on either side.
			quiet = (p == PHASES - 1);
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = $urandom_range(10, 40);
				pct   = $urandom_range(0, 1) ? 75 : 30;
				for (int j = 0; j < burst && n < PHASE_ITEMS; j++) begin
					if (!quiet && $urandom_range(0, 7) == 0) pause($urandom_range(1, 11));
					send_item(random_request(pct));
					n++;
					// Ask the receiver for a long hold, and keep sending.
					if (p == 1 && n == 40) long_hold = 1'b1;
					// Stop the sender until every expected result has come back.
					if (p == 4 && n == 100) drain();
				end
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		// Wait on, so that any stray result item is caught.
		repeat (50) @(negedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
